@@ src/page_frame_allocator_assert.svh @@
`ifndef PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/pfa_pkg.sv @@
package pfa_pkg;

   localparam int NUM_PAGES_DEF   = 32768;
   localparam int CACHE_DEPTH_DEF = 16;
   localparam int PAGE_SIZE_DEF   = 4096;

   localparam int ADDR_W   = 39;
   localparam int CMD_W    = 2;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 2;
   localparam int WORD_W   = 64;
   localparam int BIT_W    = 6;

   localparam logic [ADDR_W-1:0] MAP_BASE_RST   = 39'h0080000000;
   localparam logic [ADDR_W-1:0] LOW_LIMIT_RST  = 39'h0080000000;
   localparam logic [ADDR_W-1:0] HIGH_LIMIT_RST = 39'h0088000000;

   localparam logic [INDEX_W-1:0] REG_MAP_BASE   = 2'd0;
   localparam logic [INDEX_W-1:0] REG_LOW_LIMIT  = 2'd1;
   localparam logic [INDEX_W-1:0] REG_HIGH_LIMIT = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC_ONE = 2'd0,
      CMD_ALLOC_RUN = 2'd1,
      CMD_FREE      = 2'd2,
      CMD_UNUSED    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_NO_PAGE    = 3'd1,
      STATUS_NO_RUN     = 3'd2,
      STATUS_BAD_FREE   = 3'd3,
      STATUS_ZERO_COUNT = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_WIPE,
      OP_SCAN_RD,
      OP_ONE_CHK,
      OP_RUN_BIT,
      OP_CLR_RD,
      OP_CLR_WR,
      OP_FREE_RD,
      OP_FREE_WR,
      OP_POP,
      OP_PUSH
   } op_type;

   typedef struct packed {
      cmd_type cmd;
      logic    count_zero;
      logic    free_ok;
      logic    cache_empty;
      logic    cache_full;
      logic    word_last;
      logic    word_nz;
      logic    run_hit;
      logic    word_end;
      logic    clr_last;
   } dp_sts_type;

endpackage

@@ src/pfa_datapath.sv @@
`include "page_frame_allocator_assert.svh"

module pfa_datapath #(
   parameter int NUM_PAGES   = pfa_pkg::NUM_PAGES_DEF,
   parameter int CACHE_DEPTH = pfa_pkg::CACHE_DEPTH_DEF,
   parameter int PAGE_SIZE   = pfa_pkg::PAGE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pfa_pkg::op_type               op,
   output pfa_pkg::dp_sts_type           sts,
   input  logic [pfa_pkg::CMD_W-1:0]     req_cmd,
   input  logic [pfa_pkg::ADDR_W-1:0]    req_page_addr,
   input  logic [pfa_pkg::COUNT_W-1:0]   req_page_count,
   output logic [pfa_pkg::ADDR_W-1:0]    result_addr,
   input  logic                          csr_write,
   input  logic [pfa_pkg::INDEX_W-1:0]   csr_index,
   input  logic [pfa_pkg::ADDR_W-1:0]    csr_data
);
   import pfa_pkg::*;

   localparam int WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
   localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IW    = WW + BIT_W;
   localparam int EW    = IW + 1;
   localparam int PS_W  = $clog2(PAGE_SIZE);
   localparam int CW    = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int FW    = $clog2(CACHE_DEPTH + 1);
   localparam int HW    = ADDR_W - PS_W;

   logic [ADDR_W-1:0]  map_base_ff, low_limit_ff, high_limit_ff;
   cmd_type            cmd_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [WW-1:0]      word_ff, word_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [COUNT_W-1:0] len_ff, len_in;
   logic [IW-1:0]      start_ff, start_in;
   logic [EW-1:0]      end_ff, end_in;
   logic [ADDR_W-1:0]  res_ff, res_in;
   logic [WORD_W-1:0]  rd_data_ff;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [FW-1:0]      pop_full;
   logic [ADDR_W-1:0]  cache_ff [CACHE_DEPTH];
   logic [WORD_W-1:0]  mem [WORDS];

   logic [WW-1:0]      mem_addr;
   logic               mem_we, mem_re;
   logic [WORD_W-1:0]  mem_wdata;

   logic [ADDR_W-1:0]  diff;
   logic [IW-1:0]      free_idx;
   logic               free_ok;
   logic [WORD_W-1:0]  low_hot;
   logic [BIT_W-1:0]   low_idx;
   logic [IW-1:0]      cur_idx, hit_start;
   logic               skip, bit_val, hit;
   logic [EW-1:0]      end_m1;
   logic [WORD_W-1:0]  clr_mask;
   logic [EW-1:0]      probe;

   function automatic logic [ADDR_W-1:0] frame_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [IW-1:0] idx);
      frame_addr = base + (ADDR_W'(idx) << PS_W);
   endfunction

   assign diff     = addr_ff - map_base_ff;
   assign free_idx = diff[PS_W +: IW];
   assign free_ok  = (addr_ff[PS_W-1:0] == '0) && (addr_ff >= low_limit_ff) &&
                     (addr_ff < high_limit_ff) && (addr_ff >= map_base_ff) &&
                     (diff[ADDR_W-1:PS_W] < HW'(NUM_PAGES));

   assign low_hot = rd_data_ff & (~rd_data_ff + WORD_W'(1));
   always_comb begin
      low_idx = '0;
      for (int k = 0; k < WORD_W; k++) begin
         if (low_hot[k]) begin
            low_idx = low_idx | BIT_W'(k);
         end
      end
   end

   assign cur_idx   = {word_ff, bit_ff};
   assign bit_val   = rd_data_ff[bit_ff];
   assign skip      = (bit_ff == '0) && (rd_data_ff == '0);
   assign hit       = !skip && bit_val && ((len_ff + COUNT_W'(1)) == count_ff);
   assign hit_start = (len_ff == '0) ? cur_idx : start_ff;

   assign end_m1 = end_ff - EW'(1);
   always_comb begin
      clr_mask = '0;
      probe    = '0;
      for (int k = 0; k < WORD_W; k++) begin
         probe       = {1'b0, word_ff, BIT_W'(k)};
         clr_mask[k] = (probe >= {1'b0, start_ff}) && (probe < end_ff);
      end
   end

   assign pop_full = fill_ff - FW'(1);

   always_comb begin
      mem_addr  = word_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wdata = '0;
      case (op)
         OP_WIPE: begin
            mem_we = 1'b1;
         end
         OP_SCAN_RD, OP_CLR_RD: begin
            mem_re = 1'b1;
         end
         OP_ONE_CHK: begin
            mem_we    = (rd_data_ff != '0);
            mem_wdata = rd_data_ff & ~low_hot;
         end
         OP_CLR_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff & ~clr_mask;
         end
         OP_FREE_RD: begin
            mem_addr = free_idx[IW-1:BIT_W];
            mem_re   = 1'b1;
         end
         OP_FREE_WR: begin
            mem_addr  = free_idx[IW-1:BIT_W];
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff | (WORD_W'(1) << free_idx[BIT_W-1:0]);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
      if (op == OP_LOAD) begin
         cmd_ff   <= cmd_type'(req_cmd);
         addr_ff  <= req_page_addr;
         count_ff <= req_page_count;
      end
      if (op == OP_PUSH) begin
         cache_ff[fill_ff[CW-1:0]] <= addr_ff;
      end
   end

   always_comb begin
      word_in  = word_ff;
      bit_in   = bit_ff;
      len_in   = len_ff;
      start_in = start_ff;
      end_in   = end_ff;
      res_in   = res_ff;
      fill_in  = fill_ff;
      case (op)
         OP_LOAD: begin
            word_in = '0;
            bit_in  = '0;
            len_in  = '0;
            res_in  = '0;
         end
         OP_WIPE: begin
            word_in = (word_ff == WW'(WORDS - 1)) ? '0 : word_ff + WW'(1);
         end
         OP_SCAN_RD: begin
            bit_in = '0;
         end
         OP_ONE_CHK: begin
            if (rd_data_ff != '0) begin
               res_in = frame_addr(map_base_ff, {word_ff, low_idx});
            end else begin
               word_in = word_ff + WW'(1);
            end
         end
         OP_RUN_BIT: begin
            if (skip) begin
               len_in  = '0;
               word_in = word_ff + WW'(1);
            end else begin
               bit_in = bit_ff + BIT_W'(1);
               if (bit_ff == '1) begin
                  word_in = word_ff + WW'(1);
               end
               if (!bit_val) begin
                  len_in = '0;
               end else if (hit) begin
                  start_in = hit_start;
                  end_in   = EW'(hit_start) + EW'(count_ff);
                  res_in   = frame_addr(map_base_ff, hit_start);
                  word_in  = hit_start[IW-1:BIT_W];
               end else begin
                  start_in = hit_start;
                  len_in   = len_ff + COUNT_W'(1);
               end
            end
         end
         OP_CLR_WR: begin
            word_in = word_ff + WW'(1);
         end
         OP_POP: begin
            fill_in = pop_full;
            res_in  = cache_ff[pop_full[CW-1:0]];
         end
         OP_PUSH: begin
            fill_in = fill_ff + FW'(1);
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_base_ff   <= MAP_BASE_RST;
         low_limit_ff  <= LOW_LIMIT_RST;
         high_limit_ff <= HIGH_LIMIT_RST;
         word_ff       <= '0;
         fill_ff       <= '0;
      end else begin
         word_ff <= word_in;
         fill_ff <= fill_in;
         if (csr_write) begin
            case (csr_index)
               REG_MAP_BASE:   map_base_ff   <= csr_data;
               REG_LOW_LIMIT:  low_limit_ff  <= csr_data;
               REG_HIGH_LIMIT: high_limit_ff <= csr_data;
               default:        map_base_ff   <= map_base_ff;
            endcase
         end
      end
      bit_ff   <= bit_in;
      len_ff   <= len_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      res_ff   <= res_in;
   end

   assign result_addr     = res_ff;
   assign sts.cmd         = cmd_ff;
   assign sts.count_zero  = (count_ff == '0);
   assign sts.free_ok     = free_ok;
   assign sts.cache_empty = (fill_ff == '0);
   assign sts.cache_full  = (fill_ff == FW'(CACHE_DEPTH));
   assign sts.word_last   = (word_ff == WW'(WORDS - 1));
   assign sts.word_nz     = (rd_data_ff != '0);
   assign sts.run_hit     = hit;
   assign sts.word_end    = skip || (bit_ff == '1);
   assign sts.clr_last    = ({1'b0, word_ff} == end_m1[EW-1:BIT_W]);

   `PFA_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= FW'(CACHE_DEPTH),
                   "cache fill count above cache depth")
   `PFA_ASSERT_NEXT(a_push_grows, clock, reset, op == OP_PUSH,
                    fill_ff == $past(fill_ff) + FW'(1), "push did not grow the cache")

endmodule

@@ src/pfa_ctrl.sv @@
`include "page_frame_allocator_assert.svh"

module pfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output pfa_pkg::op_type      op,
   input  pfa_pkg::dp_sts_type  sts,
   output logic                 rsp_valid,
   output pfa_pkg::status_type  rsp_status
);
   import pfa_pkg::*;

   typedef enum logic [3:0] {
      S_WIPE,
      S_IDLE,
      S_DISPATCH,
      S_ONE_RD,
      S_ONE_CHK,
      S_RUN_RD,
      S_RUN_BIT,
      S_CLR_RD,
      S_CLR_WR,
      S_FREE_RD,
      S_FREE_WR
   } state_type;

   state_type  state_ff;
   logic       valid_ff;
   status_type status_ff;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;

   always_comb begin
      op = OP_IDLE;
      case (state_ff)
         S_WIPE:    op = OP_WIPE;
         S_IDLE:    op = start ? OP_LOAD : OP_IDLE;
         S_DISPATCH: begin
            case (sts.cmd)
               CMD_ALLOC_ONE: op = sts.cache_empty ? OP_IDLE : OP_POP;
               CMD_FREE: begin
                  if (sts.free_ok) begin
                     op = sts.cache_full ? OP_IDLE : OP_PUSH;
                  end
               end
               default:       op = OP_IDLE;
            endcase
         end
         S_ONE_RD:  op = OP_SCAN_RD;
         S_ONE_CHK: op = OP_ONE_CHK;
         S_RUN_RD:  op = OP_SCAN_RD;
         S_RUN_BIT: op = OP_RUN_BIT;
         S_CLR_RD:  op = OP_CLR_RD;
         S_CLR_WR:  op = OP_CLR_WR;
         S_FREE_RD: op = OP_FREE_RD;
         S_FREE_WR: op = OP_FREE_WR;
         default:   op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_WIPE;
         valid_ff  <= 1'b0;
         status_ff <= STATUS_OK;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            S_WIPE: begin
               if (sts.word_last) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               case (sts.cmd)
                  CMD_ALLOC_ONE: begin
                     if (sts.cache_empty) begin
                        state_ff <= S_ONE_RD;
                     end else begin
                        state_ff  <= S_IDLE;
                        valid_ff  <= 1'b1;
                        status_ff <= STATUS_OK;
                     end
                  end
                  CMD_ALLOC_RUN: begin
                     if (sts.count_zero) begin
                        state_ff  <= S_IDLE;
                        valid_ff  <= 1'b1;
                        status_ff <= STATUS_ZERO_COUNT;
                     end else begin
                        state_ff <= S_RUN_RD;
                     end
                  end
                  CMD_FREE: begin
                     if (!sts.free_ok) begin
                        state_ff  <= S_IDLE;
                        valid_ff  <= 1'b1;
                        status_ff <= STATUS_BAD_FREE;
                     end else if (sts.cache_full) begin
                        state_ff <= S_FREE_RD;
                     end else begin
                        state_ff  <= S_IDLE;
                        valid_ff  <= 1'b1;
                        status_ff <= STATUS_OK;
                     end
                  end
                  default: begin
                     state_ff  <= S_IDLE;
                     valid_ff  <= 1'b1;
                     status_ff <= STATUS_OK;
                  end
               endcase
            end
            S_ONE_RD: state_ff <= S_ONE_CHK;
            S_ONE_CHK: begin
               if (sts.word_nz) begin
                  state_ff  <= S_IDLE;
                  valid_ff  <= 1'b1;
                  status_ff <= STATUS_OK;
               end else if (sts.word_last) begin
                  state_ff  <= S_IDLE;
                  valid_ff  <= 1'b1;
                  status_ff <= STATUS_NO_PAGE;
               end else begin
                  state_ff <= S_ONE_RD;
               end
            end
            S_RUN_RD: state_ff <= S_RUN_BIT;
            S_RUN_BIT: begin
               if (sts.run_hit) begin
                  state_ff <= S_CLR_RD;
               end else if (sts.word_end) begin
                  if (sts.word_last) begin
                     state_ff  <= S_IDLE;
                     valid_ff  <= 1'b1;
                     status_ff <= STATUS_NO_RUN;
                  end else begin
                     state_ff <= S_RUN_RD;
                  end
               end
            end
            S_CLR_RD: state_ff <= S_CLR_WR;
            S_CLR_WR: begin
               if (sts.clr_last) begin
                  state_ff  <= S_IDLE;
                  valid_ff  <= 1'b1;
                  status_ff <= STATUS_OK;
               end else begin
                  state_ff <= S_CLR_RD;
               end
            end
            S_FREE_RD: state_ff <= S_FREE_WR;
            S_FREE_WR: begin
               state_ff  <= S_IDLE;
               valid_ff  <= 1'b1;
               status_ff <= STATUS_OK;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `PFA_ASSERT_NOW(a_rsp_in_idle, clock, reset, valid_ff, state_ff == S_IDLE,
                   "response strobe outside the idle state")
   `PFA_ASSERT_NEXT(a_accept_dispatch, clock, reset, (state_ff == S_IDLE) && start,
                    (state_ff == S_DISPATCH) && !valid_ff,
                    "accepted request did not move to dispatch")
   `PFA_ASSERT_NOW(a_wipe_quiet, clock, reset, state_ff == S_WIPE, !valid_ff,
                   "response strobe during the clearing pass")

endmodule

@@ src/page_frame_allocator.sv @@
// Alloc from cache, free to cache and rejected requests are answered from the dispatch state; a
// free into the bitmap reads the bitmap word and then writes it back.
// Alloc from the bitmap reads each 64-bit word and then checks it. Run alloc reads each word,
// skips an empty word, else tests 1 bit a cycle, then clears the run with a read and a write per
// word of the run. One request at a time.
// Results cannot be stalled. After reset a clearing pass zeroes the bitmap.
`include "page_frame_allocator_assert.svh"

module page_frame_allocator #(
   parameter int NUM_PAGES   = pfa_pkg::NUM_PAGES_DEF,
   parameter int CACHE_DEPTH = pfa_pkg::CACHE_DEPTH_DEF,
   parameter int PAGE_SIZE   = pfa_pkg::PAGE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pfa_pkg::CMD_W-1:0]     req_cmd,
   input  logic [pfa_pkg::ADDR_W-1:0]    req_page_addr,
   input  logic [pfa_pkg::COUNT_W-1:0]   req_page_count,
   output logic                          rsp_valid,
   output logic [pfa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [pfa_pkg::ADDR_W-1:0]    rsp_result_addr,
   input  logic                          csr_write,
   input  logic [pfa_pkg::INDEX_W-1:0]   csr_index,
   input  logic [pfa_pkg::ADDR_W-1:0]    csr_data
);
   import pfa_pkg::*;

   op_type     op;
   dp_sts_type sts;
   status_type status;

   pfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .op         (op),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp_status (status)
   );

   pfa_datapath #(
      .NUM_PAGES   (NUM_PAGES),
      .CACHE_DEPTH (CACHE_DEPTH),
      .PAGE_SIZE   (PAGE_SIZE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .sts            (sts),
      .req_cmd        (req_cmd),
      .req_page_addr  (req_page_addr),
      .req_page_count (req_page_count),
      .result_addr    (rsp_result_addr),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   assign rsp_status = status;

   `PFA_ASSERT_NOW(a_fail_zero_addr, clock, reset, rsp_valid && (status != STATUS_OK),
                   rsp_result_addr == '0, "failed request returned a non-zero address")

endmodule

@@ tb/tb_page_frame_allocator.sv @@
module tb_page_frame_allocator;
   import pfa_pkg::*;

   localparam int FRAMES     = NUM_PAGES_DEF;
   localparam int STACK_SIZE = CACHE_DEPTH_DEF;
   localparam int CYCLE_CAP  = 50000000;
   localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

   typedef struct {
      status_type       status;
      logic [ADDR_W-1:0] addr;
   } alloc_result_type;

   typedef struct {
      cmd_type           cmd;
      logic [ADDR_W-1:0] addr;
      logic [COUNT_W-1:0] count;
      bit                typed;
      status_type        status;
      logic [ADDR_W-1:0] res;
   } request_row_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [CMD_W-1:0] req_cmd = '0;
   logic [ADDR_W-1:0] req_page_addr = '0;
   logic [COUNT_W-1:0] req_page_count = '0;
   logic rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0] rsp_result_addr;
   logic csr_write = 0;
   logic [INDEX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0] csr_data = '0;

   page_frame_allocator dut (.*);

   always #4 clock = ~clock;

   bit                frame_free [FRAMES];
   logic [ADDR_W-1:0] page_stack [STACK_SIZE];
   int                stack_fill;
   logic [ADDR_W-1:0] base_reg, low_reg, high_reg;

   alloc_result_type pending_results[$];
   int  mismatches = 0;
   int  cycles = 0;
   int  sender_idle;
   bit  drain_each;

   function automatic logic [ADDR_W-1:0] frame_to_addr(int idx);
      logic [ADDR_W-1:0] off;
      off = ADDR_W'(idx) << 12;
      return base_reg + off;
   endfunction

   task automatic allocate_predict(input cmd_type c, input logic [ADDR_W-1:0] a,
                                   input logic [COUNT_W-1:0] n,
                                   output status_type st, output logic [ADDR_W-1:0] res);
      int run_len;
      int run_start;
      bit ok;
      st = STATUS_OK;
      res = '0;
      run_len = 0;
      run_start = 0;
      ok = 0;
      case (c)
         CMD_ALLOC_ONE: begin
            if (stack_fill > 0) begin
               stack_fill--;
               res = page_stack[stack_fill];
            end else begin
               st = STATUS_NO_PAGE;
               for (int i = 0; i < FRAMES; i++) begin
                  if (frame_free[i]) begin
                     frame_free[i] = 0;
                     res = frame_to_addr(i);
                     st = STATUS_OK;
                     break;
                  end
               end
            end
         end
         CMD_ALLOC_RUN: begin
            if (n == 0) begin
               st = STATUS_ZERO_COUNT;
            end else begin
               for (int i = 0; i < FRAMES; i++) begin
                  if (frame_free[i]) begin
                     if (run_len == 0) run_start = i;
                     run_len++;
                     if (run_len == int'(n)) begin
                        ok = 1;
                        break;
                     end
                  end else begin
                     run_len = 0;
                  end
               end
               if (ok) begin
                  for (int i = run_start; i < run_start + int'(n); i++) frame_free[i] = 0;
                  res = frame_to_addr(run_start);
               end else begin
                  st = STATUS_NO_RUN;
               end
            end
         end
         CMD_FREE: begin
            ok = (a[11:0] == 0) && (a >= low_reg) && (a < high_reg) && (a >= base_reg)
                 && (((a - base_reg) >> 12) < FRAMES);
            if (!ok) begin
               st = STATUS_BAD_FREE;
            end else if (stack_fill < STACK_SIZE) begin
               page_stack[stack_fill] = a;
               stack_fill++;
            end else begin
               frame_free[int'((a - base_reg) >> 12)] = 1;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("tb_page_frame_allocator NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      alloc_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d addr %h", rsp_status, rsp_result_addr);
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status || rsp_result_addr !== e.addr) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status %0d addr %h, got status %0d addr %h",
                           e.status, e.addr, rsp_status, rsp_result_addr);
            end
         end
      end
   end

   task automatic drop_start();
      @(negedge clock);
      start <= 0;
   endtask

   task automatic send_request(input request_row_type r);
      status_type st;
      logic [ADDR_W-1:0] res;
      alloc_result_type e;
      @(negedge clock);
      start <= 1;
      req_cmd <= r.cmd;
      req_page_addr <= r.addr;
      req_page_count <= r.count;
      do @(posedge clock); while (busy);
      allocate_predict(r.cmd, r.addr, r.count, st, res);
      e.status = r.typed ? r.status : st;
      e.addr = r.typed ? r.res : res;
      pending_results.push_back(e);
   endtask

   task automatic pace_sender();
      if (drain_each) begin
         drop_start();
         wait (pending_results.size() == 0);
      end else if ($urandom_range(99) < sender_idle) begin
         drop_start();
         repeat ($urandom_range(6)) @(negedge clock);
      end
   endtask

   task automatic settle();
      drop_start();
      wait (pending_results.size() == 0);
      repeat (20) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [ADDR_W-1:0] val);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 0;
      case (idx)
         REG_MAP_BASE:   base_reg = val;
         REG_LOW_LIMIT:  low_reg = val;
         REG_HIGH_LIMIT: high_reg = val;
         default: ;
      endcase
   endtask

   task automatic set_window(input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] lo,
                             input logic [ADDR_W-1:0] hi);
      settle();
      write_reg(REG_MAP_BASE, b);
      write_reg(REG_LOW_LIMIT, lo);
      write_reg(REG_HIGH_LIMIT, hi);
   endtask

   task automatic random_phase(input int items);
      request_row_type r;
      int pick;
      int idx;
      for (int k = 0; k < items; k++) begin
         r.typed = 0;
         r.status = STATUS_OK;
         r.res = '0;
         r.addr = ADDR_W'({$urandom, $urandom});
         r.count = COUNT_W'($urandom);
         pick = $urandom_range(99);
         if (pick < 45) begin
            idx = ($urandom_range(49) == 0) ? $urandom_range(FRAMES - 1) : $urandom_range(63);
            r.cmd = CMD_FREE;
            r.addr = frame_to_addr(idx);
         end else if (pick < 70) begin
            r.cmd = CMD_ALLOC_ONE;
         end else if (pick < 85) begin
            r.cmd = CMD_ALLOC_RUN;
            r.count = COUNT_W'($urandom_range(1, 8));
         end else if (pick < 95) begin
            r.cmd = CMD_FREE;
         end else begin
            r.cmd = cmd_type'($urandom_range(1, 3));
            if ($urandom_range(1) == 0) r.count = 0;
         end
         send_request(r);
         pace_sender();
      end
   endtask

   request_row_type directed[] = '{
      '{CMD_ALLOC_ONE, 39'h0,          16'd0,     1, STATUS_NO_PAGE,    39'h0},
      '{CMD_ALLOC_RUN, 39'h0,          16'd0,     1, STATUS_ZERO_COUNT, 39'h0},
      '{CMD_ALLOC_RUN, 39'h0,          16'd32768, 1, STATUS_NO_RUN,     39'h0},
      '{CMD_ALLOC_RUN, ADDR_MAX,       16'hffff,  1, STATUS_NO_RUN,     39'h0},
      '{CMD_FREE,      39'h0080000001, 16'd0,     1, STATUS_BAD_FREE,   39'h0},
      '{CMD_FREE,      39'h0,          16'd0,     1, STATUS_BAD_FREE,   39'h0},
      '{CMD_FREE,      ADDR_MAX,       16'd0,     1, STATUS_BAD_FREE,   39'h0},
      '{CMD_FREE,      39'h0088000000, 16'd0,     1, STATUS_BAD_FREE,   39'h0},
      '{CMD_FREE,      39'h007ffff000, 16'd0,     1, STATUS_BAD_FREE,   39'h0},
      '{CMD_UNUSED,    ADDR_MAX,       16'hffff,  1, STATUS_OK,         39'h0},
      '{CMD_FREE,      39'h0080000000, 16'd0,     1, STATUS_OK,         39'h0},
      '{CMD_ALLOC_ONE, 39'h0,          16'd0,     1, STATUS_OK,         39'h0080000000},
      '{CMD_FREE,      39'h0087fff000, 16'd0,     1, STATUS_OK,         39'h0},
      '{CMD_FREE,      39'h0080000000, 16'd0,     1, STATUS_OK,         39'h0},
      '{CMD_FREE,      39'h0080000000, 16'd0,     1, STATUS_OK,         39'h0},
      '{CMD_ALLOC_ONE, 39'h0,          16'd0,     1, STATUS_OK,         39'h0080000000},
      '{CMD_ALLOC_ONE, 39'h0,          16'd0,     1, STATUS_OK,         39'h0080000000},
      '{CMD_ALLOC_ONE, 39'h0,          16'd0,     1, STATUS_OK,         39'h0087fff000},
      '{CMD_ALLOC_ONE, 39'h0,          16'd0,     1, STATUS_NO_PAGE,    39'h0}
   };

   initial begin
      base_reg = MAP_BASE_RST;
      low_reg = LOW_LIMIT_RST;
      high_reg = HIGH_LIMIT_RST;
      stack_fill = 0;
      foreach (frame_free[i]) frame_free[i] = 0;
      foreach (page_stack[i]) page_stack[i] = '0;
      sender_idle = 0;
      drain_each = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (directed[i]) send_request(directed[i]);

      // The cache fills first, then further frees land in the bitmap.
      for (int k = 0; k < 24; k++) begin
         request_row_type r;
         r = '{CMD_FREE, frame_to_addr(k), 16'd0, 0, STATUS_OK, 39'h0};
         send_request(r);
      end
      random_phase(80);

      sender_idle = 50;
      set_window(39'h0, 39'h0, ADDR_MAX);
      random_phase(80);

      sender_idle = 33;
      set_window(ADDR_MAX - 39'(64 * 4096) + 39'd1, ADDR_MAX - 39'(64 * 4096) + 39'd1,
                 ADDR_MAX);
      random_phase(80);

      sender_idle = 0;
      drain_each = 1;
      set_window(MAP_BASE_RST, ADDR_MAX, 39'h0);
      random_phase(40);

      drain_each = 0;
      sender_idle = 50;
      set_window(MAP_BASE_RST, 39'h0080010000, 39'h0080100000);
      random_phase(80);

      drop_start();
      wait (pending_results.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("tb_page_frame_allocator OK");
      else
         $display("tb_page_frame_allocator NOT OK");
      $finish;
   end
endmodule
